/* hw/rtl/bmtl_pkg.sv */
// ----------------------------------------------------------------------------
// bmtl_pkg
// Shared types and constants for the bitmap text layout block.
// ----------------------------------------------------------------------------
package bmtl_pkg;

  // Item function codes (in_tuser)
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_LAYOUT = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] CFG_DEFAULT_ADVANCE = 8'd0;
  localparam logic [7:0] CFG_LINE_HEIGHT     = 8'd1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 136;

  // One input item, unpacked from the stream
  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         char_code;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [31:0]        tint_color;
    logic [11:0]        sheet_x;
    logic [11:0]        sheet_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
  } item_t;

  // Glyph table entry
  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [7:0]  w;
    logic [7:0]  h;
  } glyph_t;

  // Registered table lookup handed to the layout stage
  typedef struct packed {
    logic   hit;
    glyph_t glyph;
  } glyph_rd_t;

  // One result item
  typedef struct packed {
    logic               draw;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [7:0]         blit_width;
    logic [7:0]         blit_height;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [31:0]        tint;
    logic [15:0]        extent_width;
    logic [15:0]        extent_height;
  } result_t;

endpackage

/* hw/rtl/bitmap_text_layout.sv */
// ----------------------------------------------------------------------------
// bitmap_text_layout
// Lays out a text byte stream into blit commands using a glyph table.
// ----------------------------------------------------------------------------
// Channels:
//   in_*  : one item per transfer; in_tuser is the function (write glyph,
//           start string, lay out character), in_tdata the item fields.
//   out_* : exactly one result per input item, in order; out_tuser is the
//           draw flag, out_tdata the blit rectangle, destination, tint and
//           running text extent.
//   cfg_* : register writes (0 default advance, 1 line height), always
//           ready; write only while no item is in flight.
// From input transfer to out_tvalid an item passes the glyph table read
// register, then the cursor update into the output register. Throughput is
// one item per cycle while the receiver takes results; the glyph memory is
// read on every input transfer and written on glyph write transfers.
// Reset clears the cursor state and all glyph valid flops, so items are
// taken right after reset. When the receiver stalls, the result
// holds in the output register, one more item is taken into the lookup
// stage, and then in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module bitmap_text_layout
  import bmtl_pkg::*;
#(
  parameter int GLYPHS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: char_code, start_x, start_y, tint_color, sheet_x, sheet_y,
  //        glyph_width, glyph_height
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: func
  input  logic [1:0]            in_tuser,
  // tdata: src_x, src_y, blit_width, blit_height, dst_x, dst_y, tint,
  //        extent_width, extent_height
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: draw
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  item_t      item;
  logic       acc;
  logic       ready;
  glyph_rd_t  rd;
  result_t    result;
  logic [7:0] default_adv_r;
  logic [7:0] line_h_r;

  // Unpack the input transfer
  assign item.func         = in_tuser;
  assign item.char_code    = in_tdata[7:0];
  assign item.start_x      = in_tdata[23:8];
  assign item.start_y      = in_tdata[39:24];
  assign item.tint_color   = in_tdata[71:40];
  assign item.sheet_x      = in_tdata[83:72];
  assign item.sheet_y      = in_tdata[95:84];
  assign item.glyph_width  = in_tdata[103:96];
  assign item.glyph_height = in_tdata[111:104];

  assign in_tready = ready;
  assign acc       = in_tvalid && ready;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_adv_r <= 8'd8;
      line_h_r      <= 8'd16;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DEFAULT_ADVANCE) begin
        default_adv_r <= cfg_data;
      end else if (cfg_index == CFG_LINE_HEIGHT) begin
        line_h_r <= cfg_data;
      end
    end
  end

  bmtl_glyph_mem #(
    .GLYPHS (GLYPHS)
  ) u_glyph_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (item),
    .rd    (rd)
  );

  bmtl_layout u_layout (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .item            (item),
    .in_ready        (ready),
    .rd              (rd),
    .default_advance (default_adv_r),
    .line_height     (line_h_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .result          (result)
  );

  // Pack the result transfer
  assign out_tuser = result.draw;
  assign out_tdata = {result.extent_height, result.extent_width, result.tint,
                      result.dst_y, result.dst_x, result.blit_height,
                      result.blit_width, result.src_y, result.src_x};

endmodule

/* hw/rtl/bmtl_glyph_mem.sv */
// ----------------------------------------------------------------------------
// bmtl_glyph_mem
// Glyph table: synchronous memory with per-entry valid flops. Writes and
// reads happen on the input transfer; read data holds until the next one.
// ----------------------------------------------------------------------------
module bmtl_glyph_mem
  import bmtl_pkg::*;
#(
  parameter int GLYPHS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  item_t     item,
  output glyph_rd_t rd
);

  localparam int AW = $clog2(GLYPHS);

  glyph_t            mem [GLYPHS];
  logic [GLYPHS-1:0] valid_r;
  glyph_t            rdata_r;
  logic              hit_r;
  logic              in_range;
  logic [AW-1:0]     idx;
  logic              wr_en;

  assign in_range = ({1'b0, item.char_code} < 9'(GLYPHS));
  assign idx      = item.char_code[AW-1:0];
  assign wr_en    = acc && (item.func == FUNC_WRITE) && in_range;

  // Store the entry on a glyph write transfer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= '{sx: item.sheet_x, sy: item.sheet_y,
                    w: item.glyph_width, h: item.glyph_height};
    end
  end

  // Mark entries valid; reset clears every valid flag at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // Registered lookup, held between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (acc) begin
      hit_r <= in_range && valid_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r <= mem[idx];
    end
  end

  assign rd.hit   = hit_r;
  assign rd.glyph = rdata_r;

endmodule

/* hw/rtl/bmtl_layout.sv */
// ----------------------------------------------------------------------------
// bmtl_layout
// Layout stage: applies one item to the cursor and extent state using the
// registered glyph lookup, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bmtl_layout
  import bmtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  item_t     item,
  output logic      in_ready,
  input  glyph_rd_t rd,
  input  logic [7:0] default_advance,
  input  logic [7:0] line_height,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   result
);

  logic               s1_valid_r;
  item_t              s1_item_r;
  logic               s1_adv;
  logic               out_valid_r;
  result_t            result_r;

  logic signed [15:0] cur_x_r, cur_x_nxt;
  logic signed [15:0] cur_y_r, cur_y_nxt;
  logic signed [15:0] org_x_r, org_x_nxt;
  logic [15:0]        line_w_r, line_w_nxt;
  logic [15:0]        widest_r, widest_nxt;
  logic [15:0]        text_h_r, text_h_nxt;
  logic [31:0]        tint_r, tint_nxt;
  result_t            result_nxt;

  logic [7:0]         adv;
  logic               draw;
  logic [16:0]        sum_x, sum_y, sum_w, sum_h;
  logic signed [15:0] sat_x, sat_y;
  logic [15:0]        sat_w, sat_h;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Hold the item while its table read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= item;
    end
  end

  // Saturating adds for cursor, line width and text height
  assign draw  = rd.hit && (s1_item_r.char_code != NEWLINE_CODE);
  assign adv   = draw ? rd.glyph.w : default_advance;
  assign sum_x = {cur_x_r[15], cur_x_r} + {9'd0, adv};
  assign sum_y = {cur_y_r[15], cur_y_r} + {9'd0, line_height};
  assign sum_w = {1'b0, line_w_r} + {9'd0, adv};
  assign sum_h = {1'b0, text_h_r} + {9'd0, line_height};
  assign sat_x = (!sum_x[16] && sum_x[15]) ? 16'sh7FFF : sum_x[15:0];
  assign sat_y = (!sum_y[16] && sum_y[15]) ? 16'sh7FFF : sum_y[15:0];
  assign sat_w = sum_w[16] ? 16'hFFFF : sum_w[15:0];
  assign sat_h = sum_h[16] ? 16'hFFFF : sum_h[15:0];

  // Next state and result for the item in the layout stage
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    org_x_nxt  = org_x_r;
    line_w_nxt = line_w_r;
    widest_nxt = widest_r;
    text_h_nxt = text_h_r;
    tint_nxt   = tint_r;
    result_nxt = '0;
    result_nxt.dst_x = cur_x_r;
    result_nxt.dst_y = cur_y_r;

    unique case (s1_item_r.func)
      FUNC_START: begin
        org_x_nxt  = s1_item_r.start_x;
        cur_x_nxt  = s1_item_r.start_x;
        cur_y_nxt  = s1_item_r.start_y;
        tint_nxt   = s1_item_r.tint_color;
        line_w_nxt = '0;
        widest_nxt = '0;
        text_h_nxt = {8'd0, line_height};
        result_nxt.dst_x = s1_item_r.start_x;
        result_nxt.dst_y = s1_item_r.start_y;
      end
      FUNC_LAYOUT: begin
        if (s1_item_r.char_code == NEWLINE_CODE) begin
          widest_nxt = (line_w_r > widest_r) ? line_w_r : widest_r;
          line_w_nxt = '0;
          cur_x_nxt  = org_x_r;
          cur_y_nxt  = sat_y;
          text_h_nxt = sat_h;
        end else begin
          cur_x_nxt  = sat_x;
          line_w_nxt = sat_w;
          widest_nxt = (sat_w > widest_r) ? sat_w : widest_r;
          if (draw) begin
            result_nxt.draw        = 1'b1;
            result_nxt.src_x       = rd.glyph.sx;
            result_nxt.src_y       = rd.glyph.sy;
            result_nxt.blit_width  = rd.glyph.w;
            result_nxt.blit_height = rd.glyph.h;
          end
        end
      end
      default: begin
        // glyph writes and the unused code leave the layout state alone
      end
    endcase

    result_nxt.tint          = tint_nxt;
    result_nxt.extent_width  = (line_w_nxt > widest_nxt) ? line_w_nxt : widest_nxt;
    result_nxt.extent_height = text_h_nxt;
  end

  // Advance layout state when the item moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      org_x_r  <= '0;
      line_w_r <= '0;
      widest_r <= '0;
      text_h_r <= '0;
      tint_r   <= '0;
    end else if (s1_adv) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      org_x_r  <= org_x_nxt;
      line_w_r <= line_w_nxt;
      widest_r <= widest_nxt;
      text_h_r <= text_h_nxt;
      tint_r   <= tint_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

/* hw/rtl/bmtl_checker.sv */
// ----------------------------------------------------------------------------
// bmtl_checker
// Port-level checks for the bitmap text layout block, bound to the top.
// ----------------------------------------------------------------------------
module bmtl_checker
  import bmtl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser))
    else $error("stalled result changed");

  // A non-drawing result carries an empty sheet rectangle
  a_nodraw_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[39:0] == 40'd0)
    else $error("rectangle set without draw");

  // A fresh result follows a matching input transfer through the lookup and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching input transfer");

endmodule

bind bitmap_text_layout bmtl_checker u_bmtl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* bench/bitmap_text_layout_tb.sv */
// ----------------------------------------------------------------------------
// bitmap_text_layout_tb
// Self-checking bench for the bitmap text layout block. A scoreboard class
// keeps its own glyph table, cursor and extent state, predicts one blit
// result per input transfer and compares it field by field with each
// result transfer. Directed items cover the saturation corners, newline
// handling and unmapped glyphs. Random strings then run under several
// register settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module bitmap_text_layout_tb;
  import bmtl_pkg::*;

  localparam int          GLYPH_COUNT = 256;
  localparam logic [1:0]  FUNC_NOP    = 2'd3;  // unused function code
  localparam int          STALL_LIMIT = 2000;

  // Scoreboard: predicts blit results and checks them in order
  class layout_scoreboard;
    bit          glyph_ok[GLYPH_COUNT];
    glyph_t      glyphs[GLYPH_COUNT];
    int          cur_x, cur_y, org_x;
    int unsigned line_w, widest, text_h, tint_q;
    int unsigned adv_default, line_step;
    result_t     expected_blits[$];
    int          errors;

    function new();
      adv_default = 8;
      line_step   = 16;
    endfunction

    function int clamp_s16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int unsigned clamp_u16(int unsigned v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == CFG_DEFAULT_ADVANCE) adv_default = 32'(val);
      else if (idx == CFG_LINE_HEIGHT) line_step = 32'(val);
    endfunction

    function int pending();
      return expected_blits.size();
    endfunction

    // Note one accepted item and queue the blit it should produce
    function void note_item(item_t it);
      result_t     r;
      glyph_t      g;
      int unsigned step;
      r       = '0;
      r.dst_x = cur_x[15:0];
      r.dst_y = cur_y[15:0];
      case (it.func)
        FUNC_WRITE: begin
          if (it.char_code < GLYPH_COUNT) begin
            glyph_ok[it.char_code] = 1'b1;
            glyphs[it.char_code]   = '{sx: it.sheet_x, sy: it.sheet_y,
                                       w: it.glyph_width, h: it.glyph_height};
          end
        end
        FUNC_START: begin
          org_x   = int'($signed(it.start_x));
          cur_x   = org_x;
          cur_y   = int'($signed(it.start_y));
          tint_q  = it.tint_color;
          line_w  = 0;
          widest  = 0;
          text_h  = line_step;
          r.dst_x = cur_x[15:0];
          r.dst_y = cur_y[15:0];
        end
        FUNC_LAYOUT: begin
          if (it.char_code == NEWLINE_CODE) begin
            // close the line, return to the origin column
            if (line_w > widest) widest = line_w;
            line_w = 0;
            cur_x  = org_x;
            cur_y  = clamp_s16(cur_y + int'(line_step));
            text_h = clamp_u16(text_h + line_step);
          end else begin
            step = adv_default;
            if (it.char_code < GLYPH_COUNT && glyph_ok[it.char_code]) begin
              g             = glyphs[it.char_code];
              r.draw        = 1'b1;
              r.src_x       = g.sx;
              r.src_y       = g.sy;
              r.blit_width  = g.w;
              r.blit_height = g.h;
              step          = 32'(g.w);
            end
            cur_x  = clamp_s16(cur_x + int'(step));
            line_w = clamp_u16(line_w + step);
            if (line_w > widest) widest = line_w;
          end
        end
        default: ;
      endcase
      r.tint          = tint_q;
      r.extent_width  = 16'((line_w > widest) ? line_w : widest);
      r.extent_height = 16'(text_h);
      expected_blits.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one result transfer with the oldest expected blit
    task check_blit(logic draw, logic [OUT_DATA_W-1:0] data);
      result_t got, want;
      got.draw = draw;
      {got.extent_height, got.extent_width, got.tint, got.dst_y, got.dst_x,
       got.blit_height, got.blit_width, got.src_y, got.src_x} = data;
      if (expected_blits.size() == 0) begin
        report("result transfer with no item outstanding");
      end else begin
        want = expected_blits.pop_front();
        check_field("draw", 64'(got.draw), 64'(want.draw));
        check_field("src_x", 64'(got.src_x), 64'(want.src_x));
        check_field("src_y", 64'(got.src_y), 64'(want.src_y));
        check_field("blit_width", 64'(got.blit_width), 64'(want.blit_width));
        check_field("blit_height", 64'(got.blit_height), 64'(want.blit_height));
        check_field("dst_x", 64'(got.dst_x), 64'(want.dst_x));
        check_field("dst_y", 64'(got.dst_y), 64'(want.dst_y));
        check_field("tint", 64'(got.tint), 64'(want.tint));
        check_field("extent_width", 64'(got.extent_width), 64'(want.extent_width));
        check_field("extent_height", 64'(got.extent_height), 64'(want.extent_height));
      end
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = FUNC_NOP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_index  = '0;
  logic [7:0]            cfg_data   = '0;

  layout_scoreboard sb;
  int idle_pct  = 12;
  int stall_pct = 12;
  int quiet_cycles = 0;

  bitmap_text_layout #(.GLYPHS(GLYPH_COUNT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Track transfers on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_blit(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        sb.note_item(item_t'({in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24],
                              in_tdata[71:40], in_tdata[83:72], in_tdata[95:84],
                              in_tdata[103:96], in_tdata[111:104]}));
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic item_t rand_item(input logic [1:0] f, input logic [7:0] code);
    item_t it;
    it.func         = f;
    it.char_code    = code;
    it.start_x      = 16'($urandom);
    it.start_y      = 16'($urandom);
    it.tint_color   = $urandom;
    it.sheet_x      = 12'($urandom);
    it.sheet_y      = 12'($urandom);
    it.glyph_width  = 8'($urandom);
    it.glyph_height = 8'($urandom);
    return it;
  endfunction

  function automatic item_t glyph_item(input logic [7:0] code, input logic [11:0] sx,
                                       input logic [11:0] sy, input logic [7:0] w,
                                       input logic [7:0] h);
    item_t it;
    it              = rand_item(FUNC_WRITE, code);
    it.sheet_x      = sx;
    it.sheet_y      = sy;
    it.glyph_width  = w;
    it.glyph_height = h;
    return it;
  endfunction

  function automatic item_t start_item(input logic [15:0] x, input logic [15:0] y,
                                       input logic [31:0] tint);
    item_t it;
    it            = rand_item(FUNC_START, 8'($urandom));
    it.start_x    = x;
    it.start_y    = y;
    it.tint_color = tint;
    return it;
  endfunction

  // Send one item, idling at random first; returns on the transfer edge
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {it.glyph_height, it.glyph_width, it.sheet_y, it.sheet_x,
                  it.tint_color, it.start_y, it.start_x, it.char_code};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_layout(input logic [7:0] code);
    send_item(rand_item(FUNC_LAYOUT, code));
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write both registers, optionally preceded by a write to an unused index
  task automatic set_regs(input logic [7:0] adv, input logic [7:0] lh, input bit stray);
    logic [7:0] idx[$];
    logic [7:0] val[$];
    if (stray) begin
      idx.push_back(8'($urandom_range(2, 255)));
      val.push_back(8'($urandom));
    end
    idx.push_back(CFG_DEFAULT_ADVANCE);
    val.push_back(adv);
    idx.push_back(CFG_LINE_HEIGHT);
    val.push_back(lh);
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(negedge clk);
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random strings: mostly start + characters, some glyph writes and noise
  task automatic run_strings(input int count);
    int done;
    int len;
    int roll;
    logic [7:0] code;
    done = 0;
    while (done < count) begin
      if ($urandom_range(9) == 0) begin
        // noise: anything, no start
        repeat (5) begin
          send_item(rand_item(2'($urandom), 8'($urandom)));
          done++;
        end
      end else begin
        send_item(rand_item(FUNC_START, 8'($urandom)));
        done++;
        len = $urandom_range(1, 30);
        for (int k = 0; k < len && done < count; k++) begin
          roll = $urandom_range(99);
          code = ($urandom_range(3) != 0) ? 8'($urandom_range(32, 127)) : 8'($urandom);
          if (roll < 10)      send_item(rand_item(FUNC_WRITE, code));
          else if (roll < 12) send_item(rand_item(FUNC_NOP, code));
          else if (roll < 22) send_layout(NEWLINE_CODE);
          else                send_layout(code);
          done++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, saturation corners, newline entry, unused code
    send_layout(8'd65);
    send_layout(NEWLINE_CODE);
    send_item(rand_item(FUNC_NOP, 8'd65));
    send_item(glyph_item(8'd65, 12'd0, 12'd0, 8'd0, 8'd0));
    send_item(glyph_item(8'd255, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF));
    send_item(glyph_item(NEWLINE_CODE, 12'h123, 12'h456, 8'd7, 8'd9));
    send_item(glyph_item(8'd0, 12'hABC, 12'h543, 8'd12, 8'd20));
    send_item(start_item(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF));
    send_layout(8'd255);
    send_layout(8'd65);
    send_layout(NEWLINE_CODE);
    send_layout(8'd0);
    send_item(start_item(16'h8000, 16'h8000, 32'h0));
    repeat (3) send_layout(8'd255);
    send_layout(NEWLINE_CODE);
    send_layout(8'd200);
    send_item(rand_item(FUNC_NOP, 8'd0));
    send_item(start_item(16'h0, 16'h0, $urandom));
    send_layout(8'd0);
    send_layout(NEWLINE_CODE);
    send_layout(8'd65);
    wait_drained();

    // Saturate text height, cursor y and line width with the widest steps
    set_regs(8'd255, 8'd255, 1'b0);
    send_item(start_item(16'h8000, 16'h8000, $urandom));
    repeat (260) send_layout(NEWLINE_CODE);
    repeat (260) send_layout(8'd200);
    send_layout(NEWLINE_CODE);
    send_layout(8'd200);
    wait_drained();

    // Random strings under several register settings
    set_regs(8'd0, 8'd0, 1'b1);
    run_strings(80);
    wait_drained();

    // no idling on either side for this stretch
    idle_pct  = 0;
    stall_pct = 0;
    set_regs(8'($urandom), 8'($urandom), 1'b0);
    run_strings(80);
    wait_drained();
    idle_pct  = 12;
    stall_pct = 12;

    set_regs(8'd8, 8'd16, 1'b1);
    run_strings(40);
    wait_drained();
    run_strings(40);
    wait_drained();

    set_regs(8'd255, 8'd1, 1'b0);
    run_strings(80);
    wait_drained();

    set_regs(8'($urandom), 8'($urandom), 1'b1);
    run_strings(80);
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
